>>> sv/cabs_pkg.sv
// ----------------------------------------------------------------------------
// cabs_pkg
// Shared types and constants of the conditional ALU with barrel shifter.
// ----------------------------------------------------------------------------
package cabs_pkg;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 40;

  // Positions in the NZCV nibble
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    CondEq = 4'd0,
    CondNe = 4'd1,
    CondCs = 4'd2,
    CondCc = 4'd3,
    CondMi = 4'd4,
    CondPl = 4'd5,
    CondVs = 4'd6,
    CondVc = 4'd7,
    CondHi = 4'd8,
    CondLs = 4'd9,
    CondGe = 4'd10,
    CondLt = 4'd11,
    CondGt = 4'd12,
    CondLe = 4'd13,
    CondAl = 4'd14,
    CondNv = 4'd15
  } cond_e;

  typedef enum logic [3:0] {
    OpAnd = 4'd0,
    OpEor = 4'd1,
    OpSub = 4'd2,
    OpRsb = 4'd3,
    OpAdd = 4'd4,
    OpAdc = 4'd5,
    OpSbc = 4'd6,
    OpRsc = 4'd7,
    OpTst = 4'd8,
    OpTeq = 4'd9,
    OpCmp = 4'd10,
    OpCmn = 4'd11,
    OpOrr = 4'd12,
    OpMov = 4'd13,
    OpBic = 4'd14,
    OpMvn = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ShLsl = 2'd0,
    ShLsr = 2'd1,
    ShAsr = 2'd2,
    ShRor = 2'd3
  } shift_e;

  typedef struct packed {
    logic [3:0]  condition;
    logic [3:0]  operation;
    logic        set_flags;
    logic [31:0] operand_a;
    logic [31:0] operand_value;
    logic        imm_operand;
    logic        imm_carry;
    logic        imm_carry_valid;
    logic [1:0]  shift_kind;
    logic [7:0]  shift_amount;
    logic        shift_from_register;
    logic        dest_is_pc;
  } in_item_t;

  typedef struct packed {
    logic        executed;
    logic [31:0] result;
    logic        write_result;
    logic [3:0]  flags_nzcv;
    logic        restore_status;
  } out_item_t;

endpackage

>>> sv/cabs_shifter.sv
// ----------------------------------------------------------------------------
// cabs_shifter
// Barrel shifter for the second operand: LSL, LSR, ASR, ROR and RRX.
// ----------------------------------------------------------------------------
module cabs_shifter import cabs_pkg::*; (
  input  logic [31:0] value_i,
  input  shift_e      kind_i,
  input  logic [7:0]  amount_i,
  input  logic        from_reg_i,
  input  logic        carry_i,
  output logic [31:0] value_o,
  output logic        carry_o
);

  logic [4:0]  amt5;
  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic [32:0] asr_w;
  logic [63:0] ror_w;
  logic [31:0] fill_w;
  logic        sign_w;
  logic        big_w;
  logic        eq32_w;
  logic        zero_reg_w;
  logic        zero_imm_w;

  assign amt5       = amount_i[4:0];
  // extra bit on each side catches the last bit shifted out
  assign lsl_w      = {1'b0, value_i} << amt5;
  assign lsr_w      = {value_i, 1'b0} >> amt5;
  assign asr_w      = 33'($signed({value_i, 1'b0}) >>> amt5);
  assign ror_w      = {value_i, value_i} >> amt5;
  assign sign_w     = value_i[31];
  assign fill_w     = sign_w ? AllOnes : '0;
  assign big_w      = from_reg_i && (amount_i[7:5] != 3'd0);
  assign eq32_w     = (amount_i == 8'd32);
  assign zero_reg_w = from_reg_i && (amount_i == 8'd0);
  assign zero_imm_w = !from_reg_i && (amt5 == 5'd0);

  always_comb begin
    value_o = value_i;
    carry_o = carry_i;
    if (zero_reg_w) begin
      value_o = value_i;
      carry_o = carry_i;
    end else if (zero_imm_w) begin
      // immediate count of zero encodes #32 forms and RRX
      case (kind_i)
        ShLsl: begin
          value_o = value_i;
          carry_o = carry_i;
        end
        ShLsr: begin
          value_o = '0;
          carry_o = sign_w;
        end
        ShAsr: begin
          value_o = fill_w;
          carry_o = sign_w;
        end
        default: begin
          value_o = {carry_i, value_i[31:1]};
          carry_o = value_i[0];
        end
      endcase
    end else begin
      case (kind_i)
        ShLsl: begin
          value_o = big_w ? '0 : lsl_w[31:0];
          carry_o = big_w ? (eq32_w & value_i[0]) : lsl_w[32];
        end
        ShLsr: begin
          value_o = big_w ? '0 : lsr_w[32:1];
          carry_o = big_w ? (eq32_w & sign_w) : lsr_w[0];
        end
        ShAsr: begin
          value_o = big_w ? fill_w : asr_w[32:1];
          carry_o = big_w ? sign_w : asr_w[0];
        end
        default: begin
          value_o = ror_w[31:0];
          carry_o = ror_w[31];
        end
      endcase
    end
  end

endmodule

>>> sv/cabs_alu.sv
// ----------------------------------------------------------------------------
// cabs_alu
// Condition check, operand shift, sixteen-way ALU and NZCV flag update.
// ----------------------------------------------------------------------------
module cabs_alu import cabs_pkg::*; (
  input  in_item_t    item_i,
  input  logic [3:0]  flags_i,
  output out_item_t   res_o
);

  logic        fn, fz, fc, fv;
  logic        pass_w;
  logic [31:0] sh_val;
  logic        sh_carry;
  logic [31:0] opb;
  logic        opb_carry;
  logic [31:0] add_x, add_y;
  logic        add_cin;
  logic [32:0] sum_w;
  logic        ovf_w;
  logic [31:0] logic_r;
  logic        is_logical;
  logic [31:0] r_w;
  logic        c_new, v_new;
  logic        is_test;
  logic        restore_w;
  logic        update_w;

  assign fn = flags_i[FlagN];
  assign fz = flags_i[FlagZ];
  assign fc = flags_i[FlagC];
  assign fv = flags_i[FlagV];

  always_comb begin
    case (cond_e'(item_i.condition))
      CondEq:  pass_w = fz;
      CondNe:  pass_w = !fz;
      CondCs:  pass_w = fc;
      CondCc:  pass_w = !fc;
      CondMi:  pass_w = fn;
      CondPl:  pass_w = !fn;
      CondVs:  pass_w = fv;
      CondVc:  pass_w = !fv;
      CondHi:  pass_w = fc && !fz;
      CondLs:  pass_w = !fc || fz;
      CondGe:  pass_w = (fn == fv);
      CondLt:  pass_w = (fn != fv);
      CondGt:  pass_w = !fz && (fn == fv);
      CondLe:  pass_w = fz || (fn != fv);
      CondAl:  pass_w = 1'b1;
      default: pass_w = 1'b0;
    endcase
  end

  cabs_shifter u_shifter (
    .value_i    (item_i.operand_value),
    .kind_i     (shift_e'(item_i.shift_kind)),
    .amount_i   (item_i.shift_amount),
    .from_reg_i (item_i.shift_from_register),
    .carry_i    (fc),
    .value_o    (sh_val),
    .carry_o    (sh_carry)
  );

  always_comb begin
    if (item_i.imm_operand) begin
      opb       = item_i.operand_value;
      opb_carry = item_i.imm_carry_valid ? item_i.imm_carry : fc;
    end else begin
      opb       = sh_val;
      opb_carry = sh_carry;
    end
  end

  // Adder operand selection and logical results; reverse forms swap the operands
  always_comb begin
    add_x      = item_i.operand_a;
    add_y      = opb;
    add_cin    = 1'b0;
    logic_r    = '0;
    is_logical = 1'b0;
    case (op_e'(item_i.operation))
      OpAnd, OpTst: begin
        logic_r    = item_i.operand_a & opb;
        is_logical = 1'b1;
      end
      OpEor, OpTeq: begin
        logic_r    = item_i.operand_a ^ opb;
        is_logical = 1'b1;
      end
      OpSub, OpCmp: begin
        add_y   = ~opb;
        add_cin = 1'b1;
      end
      OpRsb: begin
        add_x   = opb;
        add_y   = ~item_i.operand_a;
        add_cin = 1'b1;
      end
      OpAdd, OpCmn: begin
        add_cin = 1'b0;
      end
      OpAdc: begin
        add_cin = fc;
      end
      OpSbc: begin
        add_y   = ~opb;
        add_cin = fc;
      end
      OpRsc: begin
        add_x   = opb;
        add_y   = ~item_i.operand_a;
        add_cin = fc;
      end
      OpOrr: begin
        logic_r    = item_i.operand_a | opb;
        is_logical = 1'b1;
      end
      OpMov: begin
        logic_r    = opb;
        is_logical = 1'b1;
      end
      OpBic: begin
        logic_r    = item_i.operand_a & ~opb;
        is_logical = 1'b1;
      end
      default: begin
        logic_r    = ~opb;
        is_logical = 1'b1;
      end
    endcase
  end

  assign sum_w = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
  assign ovf_w = ((add_x[31] ^ sum_w[31]) & (add_y[31] ^ sum_w[31]));

  assign r_w   = is_logical ? logic_r : sum_w[31:0];
  assign c_new = is_logical ? opb_carry : sum_w[32];
  assign v_new = is_logical ? fv : ovf_w;

  assign is_test   = (item_i.operation == OpTst) || (item_i.operation == OpTeq) ||
                     (item_i.operation == OpCmp) || (item_i.operation == OpCmn);
  assign restore_w = !is_test && item_i.set_flags && item_i.dest_is_pc;
  assign update_w  = pass_w && !restore_w && (item_i.set_flags || is_test);

  always_comb begin
    res_o.executed       = pass_w;
    res_o.result         = pass_w ? r_w : '0;
    res_o.write_result   = pass_w && !is_test;
    res_o.restore_status = pass_w && restore_w;
    res_o.flags_nzcv     = update_w ? {r_w[31], (r_w == '0), c_new, v_new} : flags_i;
  end

endmodule

>>> sv/conditional_alu_with_barrel_shifter_unit.sv
// ----------------------------------------------------------------------------
// conditional_alu_with_barrel_shifter_unit
// Conditional data-processing ALU with barrel shifter and stored NZCV flags.
// Each request passes the input register, then the result register.
// Throughput: one request per cycle unless the output stalls. Flags update as
// an item leaves the input register; the next item sees them with no bubble.
// Reset clears both valid bits and the NZCV flags to zero.
// ----------------------------------------------------------------------------
module conditional_alu_with_barrel_shifter_unit import cabs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // condition[3:0], operation[7:4], set_flags[8], operand_a[40:9],
  // operand_value[72:41], imm_carry[73], imm_carry_valid[74],
  // shift_kind[76:75], shift_amount[84:77], shift_from_register[85],
  // dest_is_pc[86], zero pad[87]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // imm_operand[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // executed[0], result[32:1], write_result[33], flags_nzcv[37:34],
  // restore_status[38], zero pad[39]
  output logic [OutDataW-1:0] m_axis_tdata
);

  in_item_t  in_item_d, in_item_q;
  logic      in_valid_d, in_valid_q;
  out_item_t alu_res;
  out_item_t out_item_q;
  logic      out_valid_d, out_valid_q;
  logic [3:0] flags_d, flags_q;
  logic      s_fire;
  logic      adv;

  always_comb begin
    in_item_d.condition           = s_axis_tdata[3:0];
    in_item_d.operation           = s_axis_tdata[7:4];
    in_item_d.set_flags           = s_axis_tdata[8];
    in_item_d.operand_a           = s_axis_tdata[40:9];
    in_item_d.operand_value       = s_axis_tdata[72:41];
    in_item_d.imm_operand         = s_axis_tuser;
    in_item_d.imm_carry           = s_axis_tdata[73];
    in_item_d.imm_carry_valid     = s_axis_tdata[74];
    in_item_d.shift_kind          = s_axis_tdata[76:75];
    in_item_d.shift_amount        = s_axis_tdata[84:77];
    in_item_d.shift_from_register = s_axis_tdata[85];
    in_item_d.dest_is_pc          = s_axis_tdata[86];
  end

  // advance the held request into the result register
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  cabs_alu u_alu (
    .item_i  (in_item_q),
    .flags_i (flags_q),
    .res_o   (alu_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    flags_d = adv ? alu_res.flags_nzcv : flags_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      flags_q     <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q <= in_item_d;
    end
    if (adv) begin
      out_item_q <= alu_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_item_q.restore_status, out_item_q.flags_nzcv,
                          out_item_q.write_result, out_item_q.result,
                          out_item_q.executed};

`ifndef SYNTHESIS
  a_flags_only_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q != $past(flags_q)) |-> $past(adv))
    else $error("flags changed without an item passing");

  a_out_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(adv) |-> (out_item_q.flags_nzcv == flags_q))
    else $error("result flags differ from stored flags");

  a_skip_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.executed) |->
      (out_item_q.result == '0 && !out_item_q.write_result &&
       !out_item_q.restore_status))
    else $error("skipped instruction produced an effect");

  a_restore_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.restore_status) |-> out_item_q.write_result)
    else $error("status restore without a result write");
`endif

endmodule

>>> dv/conditional_alu_with_barrel_shifter_unit_tb.sv
// ----------------------------------------------------------------------------
// conditional_alu_with_barrel_shifter_unit_tb
// Sends data-processing instructions through the stream input and checks
// each result against a cycle-free model of the condition test, shifter,
// ALU and NZCV flags. A directed set hits the edge cases, then random
// instructions follow. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module conditional_alu_with_barrel_shifter_unit_tb import cabs_pkg::*;;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // condition[3:0], operation[7:4], set_flags[8], operand_a[40:9],
  // operand_value[72:41], imm_carry[73], imm_carry_valid[74],
  // shift_kind[76:75], shift_amount[84:77], shift_from_register[85],
  // dest_is_pc[86], zero pad[87]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // imm_operand[0]
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // executed[0], result[32:1], write_result[33], flags_nzcv[37:34],
  // restore_status[38], zero pad[39]
  logic [OutDataW-1:0] m_axis_tdata;

  in_item_t    instr_backlog[$];
  out_item_t   predicted_results[$];
  logic [3:0]  model_nzcv;
  in_item_t    instr_on_bus;
  int unsigned send_wait, send_calm, recv_wait, recv_calm;
  int unsigned mismatches = 0;

  conditional_alu_with_barrel_shifter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic logic cond_holds(input cond_e cond, input logic [3:0] f);
    logic n, z, c, v;
    n = f[FlagN];
    z = f[FlagZ];
    c = f[FlagC];
    v = f[FlagV];
    case (cond)
      CondEq:  return z;
      CondNe:  return !z;
      CondCs:  return c;
      CondCc:  return !c;
      CondMi:  return n;
      CondPl:  return !n;
      CondVs:  return v;
      CondVc:  return !v;
      CondHi:  return c && !z;
      CondLs:  return !c || z;
      CondGe:  return n == v;
      CondLt:  return n != v;
      CondGt:  return !z && (n == v);
      CondLe:  return z || (n != v);
      CondAl:  return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] barrel(input logic [31:0] v, input shift_e kind,
                                         input logic [7:0] amt, input logic from_reg,
                                         input logic cin, output logic cout);
    logic        sign;
    logic [7:0]  n;
    logic [4:0]  r;
    sign = v[31];
    n = amt;
    if (!from_reg) begin
      n = {3'b000, amt[4:0]};
      // a zero count encodes LSR #32, ASR #32 and RRX
      if (n == 8'd0) begin
        case (kind)
          ShLsl: begin cout = cin; return v; end
          ShLsr: begin cout = sign; return 32'd0; end
          ShAsr: begin cout = sign; return {32{sign}}; end
          default: begin cout = v[0]; return {cin, v[31:1]}; end
        endcase
      end
    end else if (n == 8'd0) begin
      cout = cin;
      return v;
    end
    case (kind)
      ShLsl: begin
        if (n < 8'd32) begin cout = v[32 - n]; return v << n; end
        cout = (n == 8'd32) ? v[0] : 1'b0;
        return 32'd0;
      end
      ShLsr: begin
        if (n < 8'd32) begin cout = v[n - 1]; return v >> n; end
        cout = (n == 8'd32) ? sign : 1'b0;
        return 32'd0;
      end
      ShAsr: begin
        if (n < 8'd32) begin cout = v[n - 1]; return $unsigned($signed(v) >>> n); end
        cout = sign;
        return {32{sign}};
      end
      default: begin
        r = n[4:0];
        if (r == 5'd0) begin cout = sign; return v; end
        cout = v[r - 1];
        return (v >> r) | (v << (32 - r));
      end
    endcase
  endfunction

  function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                            input logic cin, output logic c,
                                            output logic v);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    c = s[32];
    v = (a[31] ^ s[31]) & (b[31] ^ s[31]);
    return s[31:0];
  endfunction

  // Execute one instruction against model_nzcv and return what the block
  // should emit for it.
  function automatic out_item_t execute_instr(input in_item_t it);
    out_item_t  res;
    logic [3:0] f;
    logic [31:0] b, r;
    logic       cf, sc, c, v, logical, test, restore;
    op_e        op;
    f = model_nzcv;
    cf = f[FlagC];
    c = cf;
    v = f[FlagV];
    sc = cf;
    op = op_e'(it.operation);
    res = '0;
    res.flags_nzcv = f;
    if (!cond_holds(cond_e'(it.condition), f)) return res;

    if (it.imm_operand) begin
      b = it.operand_value;
      sc = it.imm_carry_valid ? it.imm_carry : cf;
    end else begin
      b = barrel(it.operand_value, shift_e'(it.shift_kind), it.shift_amount,
                 it.shift_from_register, cf, sc);
    end

    logical = 1'b0;
    case (op)
      OpAnd, OpTst: begin r = it.operand_a & b; logical = 1'b1; end
      OpEor, OpTeq: begin r = it.operand_a ^ b; logical = 1'b1; end
      OpSub, OpCmp: r = add_carry(it.operand_a, ~b, 1'b1, c, v);
      OpRsb:        r = add_carry(b, ~it.operand_a, 1'b1, c, v);
      OpAdd, OpCmn: r = add_carry(it.operand_a, b, 1'b0, c, v);
      OpAdc:        r = add_carry(it.operand_a, b, cf, c, v);
      OpSbc:        r = add_carry(it.operand_a, ~b, cf, c, v);
      OpRsc:        r = add_carry(b, ~it.operand_a, cf, c, v);
      OpOrr:        begin r = it.operand_a | b; logical = 1'b1; end
      OpMov:        begin r = b; logical = 1'b1; end
      OpBic:        begin r = it.operand_a & ~b; logical = 1'b1; end
      default:      begin r = ~b; logical = 1'b1; end
    endcase
    if (logical) begin
      c = sc;
      v = f[FlagV];
    end

    test = (op == OpTst) || (op == OpTeq) || (op == OpCmp) || (op == OpCmn);
    restore = !test && it.set_flags && it.dest_is_pc;
    if (!restore && (it.set_flags || test)) begin
      f[FlagN] = r[31];
      f[FlagZ] = (r == 32'd0);
      f[FlagC] = c;
      f[FlagV] = v;
      model_nzcv = f;
    end
    res.executed       = 1'b1;
    res.result         = r;
    res.write_result   = !test;
    res.flags_nzcv     = f;
    res.restore_status = restore;
    return res;
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic in_item_t make_instr(input cond_e cond, input op_e op,
                                          input logic s, input logic [31:0] a,
                                          input logic [31:0] b, input logic imm,
                                          input logic ic, input logic icv,
                                          input shift_e kind, input logic [7:0] amt,
                                          input logic from_reg, input logic pc);
    in_item_t it;
    it.condition           = cond;
    it.operation           = op;
    it.set_flags           = s;
    it.operand_a           = a;
    it.operand_value       = b;
    it.imm_operand         = imm;
    it.imm_carry           = ic;
    it.imm_carry_valid     = icv;
    it.shift_kind          = kind;
    it.shift_amount        = amt;
    it.shift_from_register = from_reg;
    it.dest_is_pc          = pc;
    return it;
  endfunction

  function automatic logic [31:0] edge_word(input int unsigned k);
    case (k % 6)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return AllOnes;
      default: return 32'hFFFF_FFFE;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 3) == 0) return edge_word($urandom_range(0, 5));
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_reg_count();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd32;
      2:       return 8'($urandom_range(33, 255));
      3:       return {3'($urandom_range(1, 7)), 5'd0};
      default: return 8'($urandom_range(1, 31));
    endcase
  endfunction

  function automatic in_item_t random_instr();
    in_item_t it;
    it.condition = ($urandom_range(0, 1) == 0) ? CondAl : 4'($urandom_range(0, 15));
    it.operation = 4'($urandom_range(0, 15));
    it.set_flags = 1'($urandom_range(0, 1));
    it.operand_a = pick_word();
    it.operand_value = ($urandom_range(0, 7) == 0) ? it.operand_a : pick_word();
    it.imm_operand = 1'($urandom_range(0, 1));
    it.imm_carry = 1'($urandom_range(0, 1));
    it.imm_carry_valid = 1'($urandom_range(0, 1));
    it.shift_kind = 2'($urandom_range(0, 3));
    it.shift_from_register = 1'($urandom_range(0, 1));
    it.shift_amount = it.shift_from_register ? pick_reg_count()
                                             : 8'($urandom_range(0, 255));
    it.dest_is_pc = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  // Idle length per item, with runs of back-to-back items now and then
  function automatic int unsigned draw_idle(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [InDataW-1:0] pack_instr(input in_item_t it);
    return {1'b0, it.dest_is_pc, it.shift_from_register, it.shift_amount,
            it.shift_kind, it.imm_carry_valid, it.imm_carry, it.operand_value,
            it.operand_a, it.set_flags, it.operation, it.condition};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) $display("mismatch: %s got %h want %h", what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin : drive_instr
    logic busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      model_nzcv = 4'd0;
      send_wait = 0;
      send_calm = 0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_results.push_back(execute_instr(instr_on_bus));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_wait != 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (instr_backlog.size() != 0) begin
          instr_on_bus = instr_backlog.pop_front();
          s_axis_tdata <= pack_instr(instr_on_bus);
          s_axis_tuser <= instr_on_bus.imm_operand;
          s_axis_tvalid <= 1'b1;
          send_wait = draw_idle(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin : check_result
    out_item_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait = 0;
      recv_calm = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.executed       = m_axis_tdata[0];
        got.result         = m_axis_tdata[32:1];
        got.write_result   = m_axis_tdata[33];
        got.flags_nzcv     = m_axis_tdata[37:34];
        got.restore_status = m_axis_tdata[38];
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no request pending", got.result, 32'd0);
        end else begin
          want = predicted_results.pop_front();
          if (got.executed !== want.executed)
            report_mismatch("executed", 32'(got.executed), 32'(want.executed));
          if (got.result !== want.result)
            report_mismatch("result", got.result, want.result);
          if (got.write_result !== want.write_result)
            report_mismatch("write_result", 32'(got.write_result),
                            32'(want.write_result));
          if (got.flags_nzcv !== want.flags_nzcv)
            report_mismatch("flags_nzcv", 32'(got.flags_nzcv), 32'(want.flags_nzcv));
          if (got.restore_status !== want.restore_status)
            report_mismatch("restore_status", 32'(got.restore_status),
                            32'(want.restore_status));
        end
        recv_wait = draw_idle(recv_calm);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- main

  initial begin : run
    shift_e      sh_kind[16];
    logic [7:0]  sh_amt[16];
    logic        sh_reg[16];
    // one shifter corner per opcode in the opcode sweep
    sh_kind = '{ShLsl, ShLsl, ShLsr, ShAsr, ShRor, ShRor, ShLsr, ShAsr,
                ShLsl, ShLsr, ShAsr, ShRor, ShLsl, ShLsl, ShAsr, ShRor};
    sh_amt  = '{8'd0, 8'd32, 8'd33, 8'd200, 8'd64, 8'd0, 8'd32, 8'd0,
                8'd255, 8'd32, 8'd32, 8'd36, 8'd33, 8'd1, 8'd5, 8'd31};
    sh_reg  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    // zero result with supplied immediate carry
    instr_backlog.push_back(make_instr(CondAl, OpMov, 1'b1, 32'd0, 32'd0, 1'b1, 1'b1,
                                       1'b1, ShLsl, 8'd0, 1'b0, 1'b0));
    // compare of equal operands sets carry
    instr_backlog.push_back(make_instr(CondAl, OpCmp, 1'b0, 32'd5, 32'd5, 1'b1, 1'b0,
                                       1'b0, ShLsl, 8'd0, 1'b0, 1'b0));
    // overflow on subtract leaves N != V: LE passes, GT fails
    instr_backlog.push_back(make_instr(CondAl, OpCmp, 1'b0, 32'h8000_0000, 32'd1, 1'b1,
                                       1'b0, 1'b0, ShLsl, 8'd0, 1'b0, 1'b0));
    instr_backlog.push_back(make_instr(CondLe, OpMov, 1'b0, 32'd0, 32'h11, 1'b1, 1'b0,
                                       1'b0, ShLsl, 8'd0, 1'b0, 1'b0));
    instr_backlog.push_back(make_instr(CondGt, OpMov, 1'b1, 32'd0, 32'h22, 1'b1, 1'b0,
                                       1'b0, ShLsl, 8'd0, 1'b0, 1'b0));
    instr_backlog.push_back(make_instr(CondNv, OpMov, 1'b1, 32'd0, 32'h33, 1'b1, 1'b0,
                                       1'b0, ShLsl, 8'd0, 1'b0, 1'b0));
    instr_backlog.push_back(make_instr(CondAl, OpAdd, 1'b1, 32'h7FFF_FFFF, 32'd1, 1'b1,
                                       1'b0, 1'b0, ShLsl, 8'd0, 1'b0, 1'b0));
    instr_backlog.push_back(make_instr(CondAl, OpAdd, 1'b1, AllOnes, 32'd1, 1'b1,
                                       1'b0, 1'b0, ShLsl, 8'd0, 1'b0, 1'b0));
    // S with PC destination requests a status restore
    instr_backlog.push_back(make_instr(CondAl, OpSub, 1'b1, 32'd3, 32'd9, 1'b1,
                                       1'b0, 1'b0, ShLsl, 8'd0, 1'b0, 1'b1));
    // test opcode updates flags without S and never restores
    instr_backlog.push_back(make_instr(CondAl, OpTst, 1'b0, AllOnes, 32'h8000_0000, 1'b1,
                                       1'b1, 1'b0, ShLsl, 8'd0, 1'b0, 1'b1));
    for (int i = 0; i < 16; i++) begin
      instr_backlog.push_back(make_instr(CondAl, op_e'(i), 1'b1, edge_word(i),
                                         (i % 2 == 0) ? 32'h8000_0001 : edge_word(i + 3),
                                         1'b0, 1'b0, 1'b0, sh_kind[i], sh_amt[i],
                                         sh_reg[i], 1'b0));
    end
    for (int i = 0; i < 900; i++) instr_backlog.push_back(random_instr());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (instr_backlog.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("conditional_alu_with_barrel_shifter_unit_tb passed");
    end else begin
      $display("conditional_alu_with_barrel_shifter_unit_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("conditional_alu_with_barrel_shifter_unit_tb failed");
    $finish;
  end

endmodule
